FILE: rtl/lbmcs_pkg.sv
// Shared types, constants and helper functions for the D2Q9 collide-and-stream unit.
package lbmcs_pkg;

    localparam int NDIR = 9;
    localparam int QF = 30;

    localparam int GRID_WIDTH_DEF  = 128;
    localparam int GRID_HEIGHT_DEF = 128;

    // Divider: dividend is |a| << QF, divisor |b|, QB quotient bits.
    localparam int DIV_AW    = 33;
    localparam int DIV_BW    = 34;
    localparam int DIV_QB    = 32;
    localparam int DIV_LANES = 3;
    localparam int LANE_U    = 0;
    localparam int LANE_V    = 1;
    localparam int LANE_OM   = 2;

    localparam int SATW = 40;

    localparam logic [30:0] TAU_RST = 31'd590558003;
    localparam logic [29:0] LID_RST = 30'd53687091;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic signed [SATW-1:0] QONE = SATW'(64'sd1 <<< QF);

    typedef enum logic [0:0] {
        REG_TAU = 1'b0,
        REG_LID = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [DIV_AW-1:0] a;
        logic signed [DIV_BW-1:0] b;
    } t_div_in;

    typedef struct packed {
        logic [DIV_QB-1:0] q;
        logic              ovf;
        logic              neg;
        logic              dz;
    } t_div_res;

    typedef struct packed {
        logic [NDIR-1:0][31:0] f;
        logic [31:0]           rho;
        logic [NDIR-1:0]       mask;
        logic [NDIR-1:0]       lidm;
    } t_side;

    function automatic logic signed [1:0] cdx(input int d);
        case (d) inside
            1, 5, 8: return 2'sd1;
            3, 6, 7: return -2'sd1;
            default: return 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] cdy(input int d);
        case (d) inside
            2, 5, 6: return 2'sd1;
            4, 7, 8: return -2'sd1;
            default: return 2'sd0;
        endcase
    endfunction

    // Lattice weights in Q0.30 (30 fraction bits, held in a signed 30-bit value)
    function automatic logic signed [29:0] weight(input int d);
        case (d) inside
            0:          return 30'sd477218588;
            1, 2, 3, 4: return 30'sd119304647;
            default:    return 30'sd29826162;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
        if (v > SATW'(SAT_MAX)) begin
            return SAT_MAX;
        end
        if (v < SATW'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

endpackage

FILE: rtl/lbmcs_moments.sv
// Input stage: moment sums, effective relaxation time and wall classification.
module lbmcs_moments #(
    parameter int GRID_WIDTH  = lbmcs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lbmcs_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_valid,
    input  logic [lbmcs_pkg::NDIR-1:0][31:0]       i_dist,
    input  logic [30:0]                            i_eddy,
    input  logic [6:0]                             i_x,
    input  logic [6:0]                             i_y,
    input  logic [30:0]                            i_tau,
    output logic                                   o_valid,
    output lbmcs_pkg::t_div_in [lbmcs_pkg::DIV_LANES-1:0] o_lane,
    output lbmcs_pkg::t_side                       o_side
);

    localparam int GMAX = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
    localparam int GB   = $clog2(GMAX) + 1;
    localparam int CW   = ((GB > 8) ? GB : 8) + 1;

    logic                                          r_valid;
    lbmcs_pkg::t_div_in [lbmcs_pkg::DIV_LANES-1:0] r_lane, n_lane;
    lbmcs_pkg::t_side                              r_side, n_side;

    always_comb begin
        logic signed [35:0]   s_rho, s_mx, s_my;
        logic signed [CW-1:0] xp, yp;
        logic [32:0]          tau_eff;
        logic signed [31:0]   rho, mx, my;
        s_rho = '0;
        s_mx  = '0;
        s_my  = '0;
        n_side.mask = '0;
        n_side.lidm = '0;
        for (int d = 0; d < lbmcs_pkg::NDIR; d++) begin
            s_rho = s_rho + 36'($signed(i_dist[d]));
            if (lbmcs_pkg::cdx(d) == 2'sd1) begin
                s_mx = s_mx + 36'($signed(i_dist[d]));
            end else if (lbmcs_pkg::cdx(d) == -2'sd1) begin
                s_mx = s_mx - 36'($signed(i_dist[d]));
            end
            if (lbmcs_pkg::cdy(d) == 2'sd1) begin
                s_my = s_my + 36'($signed(i_dist[d]));
            end else if (lbmcs_pkg::cdy(d) == -2'sd1) begin
                s_my = s_my - 36'($signed(i_dist[d]));
            end
            xp = $signed({{(CW-7){1'b0}}, i_x}) + CW'(lbmcs_pkg::cdx(d));
            yp = $signed({{(CW-7){1'b0}}, i_y}) + CW'(lbmcs_pkg::cdy(d));
            // top wall wins over the side walls at the corners
            if (yp >= CW'(GRID_HEIGHT)) begin
                n_side.lidm[d] = 1'b1;
                n_side.mask[d] = 1'b1;
            end else if (yp < 0 || xp < 0 || xp >= CW'(GRID_WIDTH)) begin
                n_side.mask[d] = 1'b1;
            end
        end
        rho = lbmcs_pkg::sat32(lbmcs_pkg::SATW'(s_rho));
        mx  = lbmcs_pkg::sat32(lbmcs_pkg::SATW'(s_mx));
        my  = lbmcs_pkg::sat32(lbmcs_pkg::SATW'(s_my));
        tau_eff = {2'b00, i_tau} + {2'b00, i_eddy} + {1'b0, i_eddy, 1'b0};
        n_side.f   = i_dist;
        n_side.rho = rho;
        n_lane[lbmcs_pkg::LANE_U].a  = lbmcs_pkg::DIV_AW'(mx);
        n_lane[lbmcs_pkg::LANE_U].b  = lbmcs_pkg::DIV_BW'(rho);
        n_lane[lbmcs_pkg::LANE_V].a  = lbmcs_pkg::DIV_AW'(my);
        n_lane[lbmcs_pkg::LANE_V].b  = lbmcs_pkg::DIV_BW'(rho);
        n_lane[lbmcs_pkg::LANE_OM].a = lbmcs_pkg::DIV_AW'(64'sd1 <<< lbmcs_pkg::QF);
        n_lane[lbmcs_pkg::LANE_OM].b = $signed({1'b0, tau_eff});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lane <= n_lane;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_side  = r_side;

endmodule

FILE: rtl/lbmcs_divider.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
module lbmcs_divider #(
    parameter int LANES = lbmcs_pkg::DIV_LANES,
    parameter int SW    = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  lbmcs_pkg::t_div_in [LANES-1:0]        i_lane,
    input  logic [SW-1:0]                         i_side,
    output logic                                  o_valid,
    output lbmcs_pkg::t_div_res [LANES-1:0]       o_res,
    output logic [SW-1:0]                         o_side
);

    localparam int QB = lbmcs_pkg::DIV_QB;
    localparam int AW = lbmcs_pkg::DIV_AW;
    localparam int BW = lbmcs_pkg::DIV_BW;
    localparam int RW = BW + 1;
    localparam int SH = QB - lbmcs_pkg::QF;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] quo;
        logic [QB-1:0] num;
        logic [BW-1:0] den;
        logic          ovf;
        logic          neg;
        logic          dz;
    } t_work;

    logic [QB:0]              r_vld;
    t_work [LANES-1:0]        r_work [0:QB];
    t_work [LANES-1:0]        n_work [0:QB];
    logic [SW-1:0]            r_side [0:QB];

    // Set up magnitudes; a quotient too wide for QB bits is flagged and saturated later
    always_comb begin
        logic [AW-1:0] ma;
        logic [BW-1:0] mb;
        logic [RW-1:0] t;
        t_work         w;
        for (int l = 0; l < LANES; l++) begin
            ma = i_lane[l].a[AW-1] ? AW'(-i_lane[l].a) : AW'(i_lane[l].a);
            mb = i_lane[l].b[BW-1] ? BW'(-i_lane[l].b) : BW'(i_lane[l].b);
            n_work[0][l].rem = RW'(ma >> SH);
            n_work[0][l].num = QB'(ma) << lbmcs_pkg::QF;
            n_work[0][l].quo = '0;
            n_work[0][l].den = mb;
            n_work[0][l].ovf = RW'(ma >> SH) >= RW'(mb);
            n_work[0][l].neg = i_lane[l].a[AW-1] ^ i_lane[l].b[BW-1];
            n_work[0][l].dz  = (mb == '0);
        end
        // one compare and subtract per stage
        for (int k = 1; k <= QB; k++) begin
            for (int l = 0; l < LANES; l++) begin
                w = r_work[k-1][l];
                t = {w.rem[RW-2:0], w.num[QB-1]};
                if (t >= RW'(w.den)) begin
                    w.rem = t - RW'(w.den);
                    w.quo = {w.quo[QB-2:0], 1'b1};
                end else begin
                    w.rem = t;
                    w.quo = {w.quo[QB-2:0], 1'b0};
                end
                w.num = w.num << 1;
                n_work[k][l] = w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[QB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_work[0] <= n_work[0];
            r_side[0] <= i_side;
            for (int k = 1; k <= QB; k++) begin
                r_work[k] <= n_work[k];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_res[l].q   = r_work[QB][l].quo;
            o_res[l].ovf = r_work[QB][l].ovf;
            o_res[l].neg = r_work[QB][l].neg;
            o_res[l].dz  = r_work[QB][l].dz;
        end
    end

    assign o_valid = r_vld[QB];
    assign o_side  = r_side[QB];

endmodule

FILE: rtl/lbmcs_relax.sv
// BGK relaxation pipeline: equilibrium, collision, lid correction, output register.
module lbmcs_relax (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_adv,
    input  logic                                            i_valid,
    input  lbmcs_pkg::t_div_res [lbmcs_pkg::DIV_LANES-1:0]  i_res,
    input  lbmcs_pkg::t_side                                i_side,
    input  logic [29:0]                                     i_lid,
    output logic                                            o_valid,
    output logic [lbmcs_pkg::NDIR-1:0][31:0]                o_post,
    output logic [lbmcs_pkg::NDIR-1:0]                      o_mask,
    output logic [31:0]                                     o_rho
);

    localparam int ND = lbmcs_pkg::NDIR;
    localparam int NS = 8;

    function automatic logic signed [31:0] resolve(input lbmcs_pkg::t_div_res r,
                                                   input logic zero_out);
        if (r.dz && zero_out) begin
            return '0;
        end
        if (r.ovf) begin
            return r.neg ? lbmcs_pkg::SAT_MIN : lbmcs_pkg::SAT_MAX;
        end
        if (r.neg) begin
            return (r.q > 32'h8000_0000) ? lbmcs_pkg::SAT_MIN : $signed(32'(-r.q));
        end
        return (r.q > 32'h7FFF_FFFF) ? lbmcs_pkg::SAT_MAX : $signed(r.q);
    endfunction

    logic [NS-1:0]           r_vld;
    lbmcs_pkg::t_side        r_side [0:NS-1];
    logic signed [31:0]      r_om   [0:NS-2];

    logic signed [31:0]      r0_u, r0_v;
    logic signed [31:0]      r1_eu [ND];
    logic signed [31:0]      r1_wr [ND];
    logic [33:0]             r1_uu, r1_vv;
    logic [33:0]             r2_eu2 [ND];
    logic signed [31:0]      r2_eu [ND];
    logic signed [31:0]      r2_wr [ND];
    logic signed [31:0]      r2_lt [ND];
    logic [34:0]             r2_usq;
    logic signed [31:0]      r3_poly [ND];
    logic signed [31:0]      r3_wr [ND];
    logic signed [31:0]      r3_lt [ND];
    logic signed [33:0]      r4_feq [ND];
    logic signed [31:0]      r4_lt [ND];
    logic signed [31:0]      r5_diff [ND];
    logic signed [31:0]      r5_lt [ND];
    logic signed [33:0]      r6_od [ND];
    logic signed [39:0]      r6_ld [ND];
    logic [ND-1:0][31:0]     r7_post;

    logic signed [31:0]      w_lid;

    assign w_lid = 32'(signed'(i_lid));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [39:0] e;
        logic signed [63:0] p;
        logic signed [39:0] s;
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            // resolve quotients to saturated velocity and collision rate
            r0_u  <= resolve(i_res[lbmcs_pkg::LANE_U], 1'b1);
            r0_v  <= resolve(i_res[lbmcs_pkg::LANE_V], 1'b1);
            r_om[0] <= resolve(i_res[lbmcs_pkg::LANE_OM], 1'b0);
            for (int k = 1; k < NS - 1; k++) begin
                r_om[k] <= r_om[k-1];
            end
            // projected velocity, speed squares, weighted density
            p = 64'(r0_u) * 64'(r0_u);
            r1_uu <= p[63:30];
            p = 64'(r0_v) * 64'(r0_v);
            r1_vv <= p[63:30];
            for (int d = 0; d < ND; d++) begin
                e = '0;
                if (lbmcs_pkg::cdx(d) == 2'sd1) begin
                    e = e + 40'(r0_u);
                end else if (lbmcs_pkg::cdx(d) == -2'sd1) begin
                    e = e - 40'(r0_u);
                end
                if (lbmcs_pkg::cdy(d) == 2'sd1) begin
                    e = e + 40'(r0_v);
                end else if (lbmcs_pkg::cdy(d) == -2'sd1) begin
                    e = e - 40'(r0_v);
                end
                r1_eu[d] <= lbmcs_pkg::sat32(e);
                p = 64'(lbmcs_pkg::weight(d)) * 64'($signed(r_side[0].rho));
                r1_wr[d] <= p[61:30];
            end
            // squares of the projections, lid momentum term
            r2_usq <= 35'(r1_uu) + 35'(r1_vv);
            for (int d = 0; d < ND; d++) begin
                p = 64'(r1_eu[d]) * 64'(r1_eu[d]);
                r2_eu2[d] <= p[63:30];
                r2_eu[d]  <= r1_eu[d];
                r2_wr[d]  <= r1_wr[d];
                p = 64'(r1_wr[d]) * 64'(w_lid);
                r2_lt[d]  <= p[61:30];
            end
            // equilibrium polynomial
            for (int d = 0; d < ND; d++) begin
                s = lbmcs_pkg::QONE + 40'(r2_eu[d]) * 40'sd3
                    + ((40'($signed({1'b0, r2_eu2[d]})) * 40'sd9) >>> 1)
                    - ((40'($signed({1'b0, r2_usq})) * 40'sd3) >>> 1);
                r3_poly[d] <= lbmcs_pkg::sat32(s);
                r3_wr[d]   <= r2_wr[d];
                r3_lt[d]   <= r2_lt[d];
            end
            // equilibrium value
            for (int d = 0; d < ND; d++) begin
                p = 64'(r3_wr[d]) * 64'(r3_poly[d]);
                r4_feq[d] <= p[63:30];
                r4_lt[d]  <= r3_lt[d];
            end
            // distance from equilibrium
            for (int d = 0; d < ND; d++) begin
                s = 40'($signed(r_side[4].f[d])) - 40'(r4_feq[d]);
                r5_diff[d] <= lbmcs_pkg::sat32(s);
                r5_lt[d]   <= r4_lt[d];
            end
            // relaxation product, lid correction for top-wall bounces
            for (int d = 0; d < ND; d++) begin
                p = 64'(r_om[5]) * 64'(r5_diff[d]);
                r6_od[d] <= p[63:30];
                if (r_side[5].lidm[d]) begin
                    r6_ld[d] <= 40'(r5_lt[d]) * 40'sd6 * 40'(lbmcs_pkg::cdx(d));
                end else begin
                    r6_ld[d] <= '0;
                end
            end
            // output register
            for (int d = 0; d < ND; d++) begin
                s = 40'($signed(r_side[6].f[d])) - 40'(r6_od[d]) - r6_ld[d];
                r7_post[d] <= lbmcs_pkg::sat32(s);
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_post  = r7_post;
    assign o_mask  = r_side[NS-1].mask;
    assign o_rho   = r_side[NS-1].rho;

endmodule

FILE: rtl/lbm_cell_collide_stream_unit.sv
// Top level of the D2Q9 BGK collide unit with wall bounce-back classification.
//
// One lattice cell enters per clock on the slave stream while the output is
// not held off, and one result beat leaves per cell on the master stream, in
// order. The whole pipeline advances together: when the output beat is not
// taken, every stage holds and s_axis_tready drops, so nothing is lost or
// repeated. The latency is set mostly by the 33-stage restoring divider that
// forms both velocity components and the collision rate 1/tau: a set-up
// stage, then one quotient bit per stage for 32 stages; the moment sums take
// one stage ahead of it and the relaxation arithmetic eight stages after it,
// the last of which is the output register. Write tau_base (index 0) and
// lid_velocity (index 1) only while no cell is in flight.
module lbm_cell_collide_stream_unit #(
    parameter int GRID_WIDTH  = lbmcs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lbmcs_pkg::GRID_HEIGHT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream; tdata from bit 0: dist_0..dist_8 (32 each), eddy_viscosity (31),
    // cell_x (7), cell_y (7), zero pad (3)
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [335:0] s_axis_tdata,
    // master stream; tdata from bit 0: post_0..post_8 (32 each), bounce_mask (9),
    // density (32), zero pad (7)
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [335:0] m_axis_tdata,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_wdata
);

    localparam int ND = lbmcs_pkg::NDIR;

    logic [30:0]   r_tau;
    logic [29:0]   r_lid;

    logic          w_adv;
    logic          w_mom_valid;
    logic          w_div_valid;
    lbmcs_pkg::t_div_in  [lbmcs_pkg::DIV_LANES-1:0] w_lane;
    lbmcs_pkg::t_div_res [lbmcs_pkg::DIV_LANES-1:0] w_div_res;
    lbmcs_pkg::t_side    w_mom_side;
    lbmcs_pkg::t_side    w_div_side;

    logic [ND-1:0][31:0] w_dist;
    logic [ND-1:0][31:0] w_post;
    logic [ND-1:0]       w_mask;
    logic [31:0]         w_rho;

    // Hold every stage while the output beat waits
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    assign w_dist = s_axis_tdata[ND*32-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau <= lbmcs_pkg::TAU_RST;
            r_lid <= lbmcs_pkg::LID_RST;
        end else if (i_cfg_we) begin
            unique case (lbmcs_pkg::t_reg_idx'(i_cfg_index))
                lbmcs_pkg::REG_TAU: r_tau <= i_cfg_wdata;
                lbmcs_pkg::REG_LID: r_lid <= i_cfg_wdata[29:0];
                default: ;
            endcase
        end
    end

    lbmcs_moments #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_moments (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (s_axis_tvalid),
        .i_dist  (w_dist),
        .i_eddy  (s_axis_tdata[318:288]),
        .i_x     (s_axis_tdata[325:319]),
        .i_y     (s_axis_tdata[332:326]),
        .i_tau   (r_tau),
        .o_valid (w_mom_valid),
        .o_lane  (w_lane),
        .o_side  (w_mom_side)
    );

    lbmcs_divider #(
        .LANES (lbmcs_pkg::DIV_LANES),
        .SW    ($bits(lbmcs_pkg::t_side))
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_mom_valid),
        .i_lane  (w_lane),
        .i_side  (w_mom_side),
        .o_valid (w_div_valid),
        .o_res   (w_div_res),
        .o_side  (w_div_side)
    );

    lbmcs_relax u_relax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_div_valid),
        .i_res   (w_div_res),
        .i_side  (w_div_side),
        .i_lid   (r_lid),
        .o_valid (m_axis_tvalid),
        .o_post  (w_post),
        .o_mask  (w_mask),
        .o_rho   (w_rho)
    );

    assign m_axis_tdata = {7'b0, w_rho, w_mask, w_post};

    // A held pipeline keeps its occupancy
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_mom_valid) && $stable(w_div_valid))
        else $error("pipeline occupancy changed during a stall");

    // A zero density is always caught by the overflow check
    a_u_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid && w_div_res[lbmcs_pkg::LANE_U].dz
            |-> w_div_res[lbmcs_pkg::LANE_U].ovf)
        else $error("zero density not flagged as overflow");

    // A zero relaxation time saturates the rate positive
    a_om_zero_tau: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid && w_div_res[lbmcs_pkg::LANE_OM].dz
            |-> w_div_res[lbmcs_pkg::LANE_OM].ovf && !w_div_res[lbmcs_pkg::LANE_OM].neg)
        else $error("zero relaxation time not saturated");

endmodule
